[hdl/itp_pkg.sv]
`default_nettype none
package itp_pkg;

   // Stack codes
   localparam logic [1:0] OP_LPAR  = 2'd0;
   localparam logic [1:0] OP_PLUS  = 2'd1;
   localparam logic [1:0] OP_MINUS = 2'd2;
   localparam logic [1:0] OP_TIMES = 2'd3;

   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_TIMES = 8'h2A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_TERM  = 8'h00;

   localparam logic KIND_END = 1'b1;

   typedef enum logic [2:0] {
      CL_OPND,
      CL_LPAR,
      CL_RPAR,
      CL_OPER,
      CL_END
   } class_type;

   typedef enum logic [1:0] {
      EM_TOP,
      EM_PEND,
      EM_CHAR,
      EM_TERM
   } emit_sel_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POPPED
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic         load_item;
      logic         pop;
      logic         push;
      logic         drop;
      logic         load_pend;
      logic         emit;
      emit_sel_type emit_sel;
      logic         emit_last;
      logic         clr_ovf;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      class_type  cls;
      logic [1:0] code;
      logic [1:0] top;
      logic       cnt_zero;
      logic       out_free;
   } stat_type;

   function automatic class_type classify(input logic kind, input logic [7:0] ch);
      class_type cl;
      if (kind == KIND_END) begin
         cl = CL_END;
      end else begin
         case (ch)
            CH_LPAR:                     cl = CL_LPAR;
            CH_RPAR:                     cl = CL_RPAR;
            CH_PLUS, CH_MINUS, CH_TIMES: cl = CL_OPER;
            default:                     cl = CL_OPND;
         endcase
      end
      return cl;
   endfunction

   function automatic logic [1:0] op_code(input logic [7:0] ch);
      logic [1:0] c;
      case (ch)
         CH_PLUS:  c = OP_PLUS;
         CH_MINUS: c = OP_MINUS;
         default:  c = OP_TIMES;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] op_char(input logic [1:0] code);
      logic [7:0] ch;
      unique case (code)
         OP_LPAR:  ch = CH_LPAR;
         OP_PLUS:  ch = CH_PLUS;
         OP_MINUS: ch = CH_MINUS;
         default:  ch = CH_TIMES;
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

[hdl/infix_to_postfix_converter.sv]
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_ready  | req_kind, req_char_in
// rsp     | out       | rsp_valid/rsp_ready  | rsp_out_char, rsp_is_end, rsp_overflow, rsp_last
//
// An operand or '(' is loaded in ST_IDLE and handled in ST_EXEC; an operator or ')'
// pops its entries through ST_EXEC and ST_POPPED; an end item pops every stacked entry
// in ST_EXEC and then emits the terminator. Pops go one per cycle, unless a stalled rsp
// holds them, through the single registered stack read port.
// Synchronous reset empties the stack and clears the overflow flag.
// A stalled rsp holds the controller until the output register frees.
`default_nettype none
module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_kind,
   input  wire logic [7:0] req_char_in,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_is_end,
   output logic            rsp_overflow,
   output logic            rsp_last
);
   import itp_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   itp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   itp_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_kind     (req_kind),
      .req_char_in  (req_char_in),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_is_end   (rsp_is_end),
      .rsp_overflow (rsp_overflow),
      .rsp_last     (rsp_last)
   );

endmodule
`default_nettype wire

[hdl/itp_ctrl.sv]
`default_nettype none
module itp_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire itp_pkg::stat_type stat,
   output itp_pkg::cmd_type     cmd
);
   import itp_pkg::*;

   state_type state_ff, state_in;
   logic      pop_op, pop_rp, more;

   // Pop conditions on the current top of stack
   assign pop_op = !stat.cnt_zero && (stat.top != OP_LPAR) &&
                   !((stat.top != OP_TIMES) && (stat.code == OP_TIMES));
   assign pop_rp = !stat.cnt_zero && (stat.top != OP_LPAR);
   assign more   = (stat.cls == CL_OPER) ? pop_op : pop_rp;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (stat.cls)
               CL_END: begin
                  if (stat.cnt_zero && stat.out_free) state_in = ST_IDLE;
               end
               CL_OPND: begin
                  if (stat.out_free) state_in = ST_IDLE;
               end
               CL_OPER: state_in = pop_op ? ST_POPPED : ST_IDLE;
               CL_RPAR: state_in = pop_rp ? ST_POPPED : ST_IDLE;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_POPPED: begin
            if (stat.out_free && !more) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd = '0;
      cmd.emit_sel = EM_CHAR;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_item = req_valid;
         end
         ST_EXEC: begin
            case (stat.cls)
               CL_END: begin
                  if (stat.out_free) begin
                     cmd.emit = 1'b1;
                     if (!stat.cnt_zero) begin
                        cmd.emit_sel = EM_TOP;
                        cmd.pop      = 1'b1;
                     end else begin
                        cmd.emit_sel  = EM_TERM;
                        cmd.emit_last = 1'b1;
                        cmd.clr_ovf   = 1'b1;
                     end
                  end
               end
               CL_OPND: begin
                  if (stat.out_free) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_sel  = EM_CHAR;
                     cmd.emit_last = 1'b1;
                  end
               end
               CL_LPAR: cmd.push = 1'b1;
               CL_OPER: begin
                  if (pop_op) begin
                     cmd.load_pend = 1'b1;
                     cmd.pop       = 1'b1;
                  end else begin
                     cmd.push = 1'b1;
                  end
               end
               CL_RPAR: begin
                  if (pop_rp) begin
                     cmd.load_pend = 1'b1;
                     cmd.pop       = 1'b1;
                  end else begin
                     cmd.drop = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ST_POPPED: begin
            // pending pop goes out once we know whether another follows
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_sel  = EM_PEND;
               cmd.emit_last = !more;
               if (more) begin
                  cmd.load_pend = 1'b1;
                  cmd.pop       = 1'b1;
               end else if (stat.cls == CL_OPER) begin
                  cmd.push = 1'b1;
               end else begin
                  cmd.drop = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[hdl/itp_dpath.sv]
`default_nettype none
module itp_dpath #(
   parameter int STACK_DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_kind,
   input  wire logic [7:0]       req_char_in,
   input  wire itp_pkg::cmd_type cmd,
   output itp_pkg::stat_type     stat,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [7:0]            rsp_out_char,
   output logic                  rsp_is_end,
   output logic                  rsp_overflow,
   output logic                  rsp_last
);
   import itp_pkg::*;

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   logic [1:0]        mem [STACK_DEPTH];
   logic [1:0]        rd_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, cnt_dec;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic              full, push_ok;
   logic              ovf_ff, ovf_in;
   logic              kind_ff;
   logic [7:0]        char_ff, pend_ff;
   class_type         cls;
   logic [1:0]        push_code;
   logic              out_valid_ff;
   logic [7:0]        out_char_ff;
   logic              out_end_ff, out_ovf_ff, out_last_ff;
   logic              out_free;

   // Held item
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff <= req_kind;
         char_ff <= req_char_in;
      end
   end

   assign cls       = classify(kind_ff, char_ff);
   assign push_code = (cls == CL_LPAR) ? OP_LPAR : op_code(char_ff);

   // Stack count and overflow flag
   assign full    = (cnt_ff == CNT_W'(STACK_DEPTH));
   assign push_ok = cmd.push && !full;
   assign cnt_dec = cnt_ff - CNT_W'(1);

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.pop || (cmd.drop && (cnt_ff != '0))) begin
         cnt_in = cnt_dec;
      end else if (push_ok) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_comb begin
      ovf_in = ovf_ff;
      if (cmd.push && full) begin
         ovf_in = 1'b1;
      end else if (cmd.clr_ovf) begin
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end

   // Stack memory; read port tracks the next top of stack
   assign wr_addr = cnt_ff[ADDR_W-1:0];
   assign rd_addr = cnt_in[ADDR_W-1:0] - ADDR_W'(1);

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[wr_addr] <= push_code;
      end
      rd_ff <= mem[rd_addr];
   end

   // Popped operator waiting for its last flag
   always_ff @(posedge clock) begin
      if (cmd.load_pend) begin
         pend_ff <= op_char(rd_ff);
      end
   end

   // Output register
   assign out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_last_ff <= cmd.emit_last;
         out_end_ff  <= (cmd.emit_sel == EM_TERM);
         out_ovf_ff  <= (cmd.emit_sel == EM_TERM) && ovf_ff;
         case (cmd.emit_sel)
            EM_TOP:  out_char_ff <= op_char(rd_ff);
            EM_PEND: out_char_ff <= pend_ff;
            EM_CHAR: out_char_ff <= char_ff;
            default: out_char_ff <= CH_TERM;
         endcase
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_is_end   = out_end_ff;
   assign rsp_overflow = out_ovf_ff;
   assign rsp_last     = out_last_ff;

   assign stat.cls      = cls;
   assign stat.code     = op_code(char_ff);
   assign stat.top      = rd_ff;
   assign stat.cnt_zero = (cnt_ff == '0);
   assign stat.out_free = out_free;

   // Checks
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (cnt_ff != '0))
      else $error("pop on empty stack");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("output register overwritten");

   a_ovf_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && (cmd.emit_sel == EM_TERM)) |=> !ovf_ff)
      else $error("overflow flag not cleared after terminator");

endmodule
`default_nettype wire

[dv/tb_infix_to_postfix_converter.sv]
`timescale 1ns / 100ps
module tb_infix_to_postfix_converter;
   import itp_pkg::*;

   localparam int STACK_DEPTH = 16;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned TOTAL_ITEMS = 280;
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam logic KIND_CHAR = ~KIND_END;

   // One postfix character as it leaves the block
   typedef struct {
      logic [7:0] out_char;
      logic       is_end;
      logic       overflow;
      logic       last;
   } postfix_char_type;

   // Tracks the operator stack and queues the postfix output each transfer releases
   class postfix_ledger;
      logic [1:0]       opstk [STACK_DEPTH];
      int unsigned      used;
      bit               ovf_sticky;
      postfix_char_type batch[$];
      postfix_char_type due[$];
      int unsigned      mismatches;

      function new();
         used = 0;
         ovf_sticky = 0;
         mismatches = 0;
      endfunction

      function int unsigned pending();
         return due.size();
      endfunction

      function logic [7:0] code_char(input logic [1:0] c);
         case (c)
            OP_LPAR:  return CH_LPAR;
            OP_PLUS:  return CH_PLUS;
            OP_MINUS: return CH_MINUS;
            default:  return CH_TIMES;
         endcase
      endfunction

      function void emit(input logic [7:0] ch, input logic e, input logic o);
         postfix_char_type p;
         p.out_char = ch;
         p.is_end = e;
         p.overflow = o;
         p.last = 1'b0;
         batch.push_back(p);
      endfunction

      function void pop_top();
         used--;
         emit(code_char(opstk[used]), 1'b0, 1'b0);
      endfunction

      // Push onto a full stack is dropped and remembered
      function void push_code(input logic [1:0] c);
         if (used >= STACK_DEPTH) begin
            ovf_sticky = 1'b1;
         end else begin
            opstk[used] = c;
            used++;
         end
      endfunction

      function void take_infix(input logic kind, input logic [7:0] ch);
         logic [1:0] code;
         batch.delete();
         if (kind == KIND_END) begin
            while (used > 0) pop_top();
            emit(CH_TERM, 1'b1, ovf_sticky);
            ovf_sticky = 1'b0;
         end else if (ch == CH_LPAR) begin
            push_code(OP_LPAR);
         end else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_TIMES) begin
            code = (ch == CH_PLUS) ? OP_PLUS : (ch == CH_MINUS) ? OP_MINUS : OP_TIMES;
            // left-assoc: pop equal or higher precedence, stop at '('
            while (used > 0) begin
               if (opstk[used-1] == OP_LPAR) break;
               if (code == OP_TIMES && opstk[used-1] != OP_TIMES) break;
               pop_top();
            end
            push_code(code);
         end else if (ch == CH_RPAR) begin
            // unmatched ')' drains to the bottom and is otherwise ignored
            while (used > 0 && opstk[used-1] != OP_LPAR) pop_top();
            if (used > 0) used--;
         end else begin
            emit(ch, 1'b0, 1'b0);
         end
         if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
         foreach (batch[i]) due.push_back(batch[i]);
      endfunction

      function void match_postfix(input logic [7:0] ch, input logic e, input logic o,
                                  input logic l);
         postfix_char_type x;
         if (due.size() == 0) begin
            $error("unexpected result: out_char=%0h is_end=%0b", ch, e);
            mismatches++;
            return;
         end
         x = due.pop_front();
         if (ch !== x.out_char) begin
            $error("out_char: expected %0h, actual %0h", x.out_char, ch);
            mismatches++;
         end
         if (e !== x.is_end) begin
            $error("is_end: expected %0b, actual %0b", x.is_end, e);
            mismatches++;
         end
         if (o !== x.overflow) begin
            $error("overflow: expected %0b, actual %0b", x.overflow, o);
            mismatches++;
         end
         if (l !== x.last) begin
            $error("last: expected %0b, actual %0b", x.last, l);
            mismatches++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_kind = 1'b0;
   logic [7:0] req_char_in = 8'h00;
   logic       rsp_ready = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic [7:0] rsp_out_char;
   logic       rsp_is_end;
   logic       rsp_overflow;
   logic       rsp_last;

   postfix_ledger ledger;
   int unsigned   items_sent = 0;
   int unsigned   cycle_count = 0;
   bit            no_idle = 1'b0;
   bit            hold_req = 1'b0;

   infix_to_postfix_converter #(
      .STACK_DEPTH(STACK_DEPTH)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_char_in (req_char_in),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_out_char(rsp_out_char),
      .rsp_is_end  (rsp_is_end),
      .rsp_overflow(rsp_overflow),
      .rsp_last    (rsp_last)
   );

   always #5 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_infix_to_postfix_converter: FAIL");
         $finish;
      end
   end

   // Sender gap: mostly none, some short, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   function automatic logic [7:0] pick_operand();
      logic [7:0] ch;
      do begin
         ch = 8'($urandom_range(0, 255));
      end while (ch == CH_LPAR || ch == CH_RPAR || ch == CH_PLUS ||
                 ch == CH_MINUS || ch == CH_TIMES);
      return ch;
   endfunction

   function automatic logic [7:0] pick_operator();
      case ($urandom_range(0, 2))
         0:       return CH_PLUS;
         1:       return CH_MINUS;
         default: return CH_TIMES;
      endcase
   endfunction

   // Terms joined by operators; a term is an operand or a parenthesized sub-expression
   function automatic void grow_expr(ref logic [7:0] q[$], input int unsigned lvl);
      int unsigned n;
      n = $urandom_range(0, 3);
      for (int k = 0; k <= n; k++) begin
         if (k > 0) q.push_back(pick_operator());
         if (lvl > 0 && $urandom_range(0, 2) == 0) begin
            q.push_back(CH_LPAR);
            grow_expr(q, lvl - 1);
            q.push_back(CH_RPAR);
         end else begin
            q.push_back(pick_operand());
         end
      end
   endfunction

   // Entered at a falling edge; returns at a falling edge
   task automatic send_item(input logic kind, input logic [7:0] ch);
      int unsigned gap;
      req_valid <= 1'b1;
      req_kind <= kind;
      req_char_in <= ch;
      do @(posedge clock); while (!req_ready);
      ledger.take_infix(kind, ch);
      items_sent++;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(KIND_CHAR, s[i]);
   endtask

   task automatic send_end();
      send_item(KIND_END, 8'($urandom_range(0, 255)));
   endtask

   // Stop offering until every queued result has come back, then let the block settle
   task automatic drain_results();
      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Receiver: check at the rising edge, change ready at the falling edge
   initial begin
      int unsigned stall_left;
      int unsigned r;
      logic        nxt;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            ledger.match_postfix(rsp_out_char, rsp_is_end, rsp_overflow, rsp_last);
         if (hold_req) begin
            hold_req = 1'b0;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            nxt = 1'b0;
         end else if (no_idle) begin
            nxt = 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               nxt = 1'b1;
            end else if (r < 96) begin
               stall_left = $urandom_range(0, 2);
               nxt = 1'b0;
            end else begin
               stall_left = $urandom_range(10, 40);
               nxt = 1'b0;
            end
         end
         @(negedge clock);
         rsp_ready <= nxt;
      end
   end

   // Stimulus
   initial begin
      logic [7:0]  tokens[$];
      int unsigned pick;
      int unsigned n;
      bit          pressed;
      ledger = new();
      pressed = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty expression, every operator and paren case, unmatched ')'
      send_end();
      send_text("(a-b)*c+d*e-f");
      send_end();
      send_text("a+)");
      send_end();
      // operand extremes; char ignored on the end item
      send_item(KIND_CHAR, 8'h00);
      send_item(KIND_CHAR, 8'hFF);
      send_item(KIND_END, 8'hFF);

      while (items_sent < TOTAL_ITEMS) begin
         no_idle = ($urandom_range(0, 9) == 0);
         tokens.delete();
         pick = $urandom_range(0, 99);
         if (!pressed && items_sent > (TOTAL_ITEMS / 2)) begin
            // Long receiver hold while the sender keeps offering operands
            pressed = 1'b1;
            no_idle = 1'b1;
            hold_req = 1'b1;
            repeat (30) tokens.push_back(pick_operand());
            foreach (tokens[i]) send_item(KIND_CHAR, tokens[i]);
            send_end();
            drain_results();
            no_idle = 1'b0;
         end else if (pick < 65) begin
            grow_expr(tokens, 3);
            foreach (tokens[i]) send_item(KIND_CHAR, tokens[i]);
            send_end();
         end else if (pick < 78) begin
            // Deep nesting, often past the stack depth
            n = $urandom_range(6, 14);
            repeat (n) begin
               tokens.push_back(CH_LPAR);
               if ($urandom_range(0, 1) == 1) tokens.push_back(pick_operator());
            end
            tokens.push_back(pick_operand());
            repeat ($urandom_range(0, n)) tokens.push_back(CH_RPAR);
            foreach (tokens[i]) send_item(KIND_CHAR, tokens[i]);
            send_end();
         end else begin
            // Noise: raw bytes, stray parens and operators, early ends
            repeat ($urandom_range(1, 8)) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: send_item(KIND_CHAR, 8'($urandom_range(0, 255)));
                  4, 5:       send_item(KIND_CHAR, pick_operator());
                  6:          send_item(KIND_CHAR, CH_LPAR);
                  7, 8:       send_item(KIND_CHAR, CH_RPAR);
                  default:    send_end();
               endcase
            end
            if ($urandom_range(0, 1) == 1) send_end();
         end
      end

      drain_results();
      if (ledger.mismatches == 0)
         $display("tb_infix_to_postfix_converter: PASS");
      else
         $display("tb_infix_to_postfix_converter: FAIL");
      $finish;
   end

endmodule
